### design/assert_macros.svh
// Assertion macros shared by the design files.
// Each check is sampled on the rising edge of clk and is held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define BTOP_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
// The consequent must hold in the cycle after the antecedent.
`define BTOP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define BTOP_ASSERT_IMPLY(lbl, ante, cons)
`define BTOP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### design/btop_pkg.sv
package btop_pkg;

    // Tree size and the storage widths that follow from it.
    localparam int MAX_STEPS  = 1024;
    localparam int NODE_DEPTH = MAX_STEPS + 1;
    localparam int ADDR_W     = $clog2(NODE_DEPTH);

    // Fixed field widths.
    localparam int PRICE_W    = 32;
    localparam int FACTOR_W   = 32;
    localparam int WIDE_W     = 63;
    localparam int STEPS_W    = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Fixed-point constants.
    localparam logic [WIDE_W-1:0]   Q30_ONE  = 63'h0000_0000_4000_0000;
    localparam logic [WIDE_W-1:0]   WIDE_CAP = 63'h4000_0000_0000_0000;
    localparam logic [FACTOR_W-1:0] Q31_ONE  = 32'h8000_0000;
    localparam logic [WIDE_W-1:0]   PRICE_MAX_WIDE = 63'h0000_0000_FFFF_FFFF;

    // Step counter type and last step shared by both arithmetic units; each unit has its own multiplier.
    typedef logic [2:0] unit_step_t;
    localparam unit_step_t UNIT_LAST_STEP = 3'd4;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UP_FACTOR     = 3'd0,
        REG_DOWN_FACTOR   = 3'd1,
        REG_PROB_UP       = 3'd2,
        REG_STEP_DISCOUNT = 3'd3,
        REG_TREE_STEPS    = 3'd4,
        REG_EXERCISE      = 3'd5
    } cfg_index_t;

endpackage

### design/btop_mulq30.sv
// Iterative Q30 multiplier: floor(a*b / 2^30) with both operands and the
// result capped at 2^62, built from four 32x32 partial products.
module btop_mulq30 import btop_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WIDE_W-1:0] a,
    input  logic [WIDE_W-1:0] b,
    output logic              busy,
    output logic [WIDE_W-1:0] result
);

    logic              busy_reg;
    unit_step_t        step_reg;
    logic [WIDE_W-1:0] a_reg;
    logic [WIDE_W-1:0] b_reg;
    logic [63:0]       prod_reg;
    logic [63:0]       hh_reg;
    logic [63:0]       mid_reg;
    logic [WIDE_W-1:0] result_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [63:0] acc;
    logic        cap_hit;

    // Operand halves for the current partial product.
    always_comb
    begin
        case (step_reg)
            3'd0:
            begin
                mul_a = {1'b0, a_reg[62:32]};
                mul_b = {1'b0, b_reg[62:32]};
            end
            3'd1:
            begin
                mul_a = {1'b0, a_reg[62:32]};
                mul_b = b_reg[31:0];
            end
            3'd2:
            begin
                mul_a = a_reg[31:0];
                mul_b = {1'b0, b_reg[62:32]};
            end
            default:
            begin
                mul_a = a_reg[31:0];
                mul_b = b_reg[31:0];
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // Recombination of the partial products with the overflow caps.
    assign cap_hit = (hh_reg >= 64'h0000_0000_1000_0000) ||
                     (mid_reg >= 64'h1000_0000_0000_0000);
    assign acc = (hh_reg << 34) + (mid_reg << 2) + (prod_reg >> 30);

    // Control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == UNIT_LAST_STEP)
            begin
                busy_reg <= 1'b0;
            end
            step_reg <= step_reg + 3'd1;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= (a > WIDE_CAP) ? WIDE_CAP : a;
            b_reg <= (b > WIDE_CAP) ? WIDE_CAP : b;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                3'd0: prod_reg <= mul_p;
                3'd1:
                begin
                    hh_reg   <= prod_reg;
                    prod_reg <= mul_p;
                end
                3'd2:
                begin
                    mid_reg  <= prod_reg;
                    prod_reg <= mul_p;
                end
                3'd3:
                begin
                    mid_reg  <= mid_reg + prod_reg;
                    prod_reg <= mul_p;
                end
                default:
                begin
                    if (cap_hit || (acc > {1'b0, WIDE_CAP}))
                    begin
                        result_reg <= WIDE_CAP;
                    end
                    else
                    begin
                        result_reg <= acc[WIDE_W-1:0];
                    end
                end
            endcase
        end
    end

    assign busy   = busy_reg;
    assign result = result_reg;

endmodule

### design/btop_rollback.sv
// Iterative roll-back of one node pair:
// floor(disc * floor((p*up + (1-p)*down) / 2^31) / 2^31).
module btop_rollback import btop_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [FACTOR_W-1:0] prob,
    input  logic [FACTOR_W-1:0] disc,
    input  logic [PRICE_W-1:0] up_val,
    input  logic [PRICE_W-1:0] dn_val,
    output logic               busy,
    output logic [PRICE_W-1:0] result
);

    logic                busy_reg;
    unit_step_t          step_reg;
    logic [FACTOR_W-1:0] prob_reg;
    logic [FACTOR_W-1:0] disc_reg;
    logic [PRICE_W-1:0]  up_reg;
    logic [PRICE_W-1:0]  dn_reg;
    logic [63:0]         prod_reg;
    logic [63:0]         sum_reg;
    logic [PRICE_W-1:0]  mix_reg;
    logic [PRICE_W-1:0]  result_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [63:0] mix_sum;

    // Operands for the shared multiplier.
    always_comb
    begin
        case (step_reg)
            3'd0:
            begin
                mul_a = prob_reg;
                mul_b = up_reg;
            end
            3'd1:
            begin
                mul_a = Q31_ONE - prob_reg;
                mul_b = dn_reg;
            end
            default:
            begin
                mul_a = disc_reg;
                mul_b = mix_reg;
            end
        endcase
    end

    assign mul_p   = 64'(mul_a) * 64'(mul_b);
    assign mix_sum = sum_reg + prod_reg;

    // Control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == UNIT_LAST_STEP)
            begin
                busy_reg <= 1'b0;
            end
            step_reg <= step_reg + 3'd1;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prob_reg <= prob;
            disc_reg <= disc;
            up_reg   <= up_val;
            dn_reg   <= dn_val;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                3'd0: prod_reg <= mul_p;
                3'd1:
                begin
                    sum_reg  <= prod_reg;
                    prod_reg <= mul_p;
                end
                3'd2: mix_reg <= mix_sum[62:31];
                3'd3: prod_reg <= mul_p;
                default: result_reg <= prod_reg[62:31];
            endcase
        end
    end

    assign busy   = busy_reg;
    assign result = result_reg;

endmodule

### design/binomial_tree_option_pricer.sv
// Channel   | Ports                                       | Handshake
// ----------+---------------------------------------------+----------------------------
// request   | spot_price, strike_price                    | start high while busy low
// result    | call_value, put_value                       | done, one-cycle strobe
// config    | write_index, write_data                     | write_en, taken at once
//
// One request at a time; n is the clamped step count. American style also works out each
// node price again during the roll-back, through the iterative Q30 multiplier and the
// power store, for its early-exercise check.
// Reset returns the sequencer to idle and loads the configuration registers with defaults; the stores need no clearing.
// The result strobe cannot be held off: call_value and put_value are valid with done and
// hold only until the next request reaches its node updates.
`include "assert_macros.svh"
module binomial_tree_option_pricer import btop_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [PRICE_W-1:0]    spot_price,
    input  logic [PRICE_W-1:0]    strike_price,
    output logic                  done,
    output logic [PRICE_W-1:0]    call_value,
    output logic [PRICE_W-1:0]    put_value,
    input  logic                  write_en,
    input  logic [CFG_IDX_W-1:0]  write_index,
    input  logic [CFG_DATA_W-1:0] write_data
);

    typedef enum logic [16:0] {
        S_IDLE    = 17'h00001,
        S_POW_MUP = 17'h00002,
        S_POW_WUP = 17'h00004,
        S_POW_MDN = 17'h00008,
        S_POW_WDN = 17'h00010,
        S_PR_RDU  = 17'h00020,
        S_PR_RDD  = 17'h00040,
        S_PR_M1   = 17'h00080,
        S_PR_W1   = 17'h00100,
        S_PR_M2   = 17'h00200,
        S_PR_W2   = 17'h00400,
        S_LEAF_WR = 17'h00800,
        S_ND_RD0  = 17'h01000,
        S_ND_RD1  = 17'h02000,
        S_ND_RB   = 17'h04000,
        S_ND_WAIT = 17'h08000,
        S_ND_WR   = 17'h10000
    } state_t;

    // Configuration registers.
    logic [FACTOR_W-1:0] up_factor_reg;
    logic [FACTOR_W-1:0] down_factor_reg;
    logic [FACTOR_W-1:0] prob_up_reg;
    logic [FACTOR_W-1:0] step_discount_reg;
    logic [STEPS_W-1:0]  tree_steps_reg;
    logic                exercise_style_reg;

    // Sequencer and working registers.
    state_t              state_reg, state_next;
    logic                done_reg, done_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [ADDR_W-1:0]   j_reg, j_next;
    logic                leaf_reg, leaf_next;
    logic [ADDR_W-1:0]   n_reg, n_next;
    logic [FACTOR_W-1:0] p_reg, p_next;
    logic [FACTOR_W-1:0] disc_reg, disc_next;
    logic                amer_reg, amer_next;
    logic [PRICE_W-1:0]  spot_reg, spot_next;
    logic [PRICE_W-1:0]  strike_reg, strike_next;
    logic [WIDE_W-1:0]   up_cur_reg, up_cur_next;
    logic [WIDE_W-1:0]   dn_cur_reg, dn_cur_next;
    logic [WIDE_W-1:0]   up_sel_reg, up_sel_next;
    logic [WIDE_W-1:0]   dn_sel_reg, dn_sel_next;
    logic [PRICE_W-1:0]  price_reg, price_next;
    logic [PRICE_W-1:0]  call_up_reg, call_up_next;
    logic [PRICE_W-1:0]  put_up_reg, put_up_next;
    logic [PRICE_W-1:0]  call_out_reg, call_out_next;
    logic [PRICE_W-1:0]  put_out_reg, put_out_next;

    // Power store {u^k, d^k} and node store {call, put}.
    logic [2*WIDE_W-1:0]  pow_mem [NODE_DEPTH];
    logic [2*WIDE_W-1:0]  pow_rdata_reg;
    logic                 pow_we, pow_re;
    logic [ADDR_W-1:0]    pow_waddr, pow_raddr;
    logic [2*WIDE_W-1:0]  pow_wdata;
    logic [2*PRICE_W-1:0] node_mem [NODE_DEPTH];
    logic [2*PRICE_W-1:0] node_rdata_reg;
    logic                 node_we, node_re;
    logic [ADDR_W-1:0]    node_waddr, node_raddr;
    logic [2*PRICE_W-1:0] node_wdata;

    // Arithmetic units.
    logic                mul_start, mul_busy;
    logic [WIDE_W-1:0]   mul_a, mul_b, mul_res;
    logic                rb_start, rb_call_busy, rb_put_busy;
    logic [PRICE_W-1:0]  rb_call_res, rb_put_res;

    // Helper values.
    logic [ADDR_W-1:0]   n_clamped;
    logic [WIDE_W-1:0]   price_sat;
    logic [PRICE_W-1:0]  node_call, node_put;

    // Configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_factor_reg      <= 32'h4000_0000;
            down_factor_reg    <= 32'h4000_0000;
            prob_up_reg        <= 32'h4000_0000;
            step_discount_reg  <= Q31_ONE;
            tree_steps_reg     <= 11'd1;
            exercise_style_reg <= 1'b0;
        end
        else if (write_en)
        begin
            case (cfg_index_t'(write_index))
                REG_UP_FACTOR:     up_factor_reg      <= write_data;
                REG_DOWN_FACTOR:   down_factor_reg    <= write_data;
                REG_PROB_UP:       prob_up_reg        <= write_data;
                REG_STEP_DISCOUNT: step_discount_reg  <= write_data;
                REG_TREE_STEPS:    tree_steps_reg     <= write_data[STEPS_W-1:0];
                REG_EXERCISE:      exercise_style_reg <= write_data[0];
                default:           ;
            endcase
        end
    end

    // Step count clamped to one through MAX_STEPS, one less than the store depth.
    always_comb
    begin
        if (tree_steps_reg == '0)
        begin
            n_clamped = ADDR_W'(1);
        end
        else if (32'(tree_steps_reg) > MAX_STEPS)
        begin
            n_clamped = ADDR_W'(MAX_STEPS);
        end
        else
        begin
            n_clamped = ADDR_W'(tree_steps_reg);
        end
    end

    // Node price saturation and the rolled-back values, with early exercise in American style.
    assign price_sat = (mul_res > PRICE_MAX_WIDE) ? PRICE_MAX_WIDE : mul_res;

    always_comb
    begin
        node_call = rb_call_res;
        node_put  = rb_put_res;
        if (amer_reg)
        begin
            if ((price_reg > strike_reg) && ((price_reg - strike_reg) > rb_call_res))
            begin
                node_call = price_reg - strike_reg;
            end
            if ((strike_reg > price_reg) && ((strike_reg - price_reg) > rb_put_res))
            begin
                node_put = strike_reg - price_reg;
            end
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        idx_next      = idx_reg;
        j_next        = j_reg;
        leaf_next     = leaf_reg;
        n_next        = n_reg;
        p_next        = p_reg;
        disc_next     = disc_reg;
        amer_next     = amer_reg;
        spot_next     = spot_reg;
        strike_next   = strike_reg;
        up_cur_next   = up_cur_reg;
        dn_cur_next   = dn_cur_reg;
        up_sel_next   = up_sel_reg;
        dn_sel_next   = dn_sel_reg;
        price_next    = price_reg;
        call_up_next  = call_up_reg;
        put_up_next   = put_up_reg;
        call_out_next = call_out_reg;
        put_out_next  = put_out_reg;
        pow_we        = 1'b0;
        pow_waddr     = idx_reg;
        pow_wdata     = {up_cur_reg, mul_res};
        pow_re        = 1'b0;
        pow_raddr     = idx_reg;
        node_we       = 1'b0;
        node_waddr    = j_reg;
        node_wdata    = {node_call, node_put};
        node_re       = 1'b0;
        node_raddr    = j_reg;
        mul_start     = 1'b0;
        mul_a         = mul_res;
        mul_b         = dn_sel_reg;
        rb_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    spot_next   = spot_price;
                    strike_next = strike_price;
                    n_next      = n_clamped;
                    p_next      = (prob_up_reg > Q31_ONE) ? Q31_ONE : prob_up_reg;
                    disc_next   = (step_discount_reg > Q31_ONE) ? Q31_ONE : step_discount_reg;
                    amer_next   = exercise_style_reg;
                    up_cur_next = Q30_ONE;
                    dn_cur_next = Q30_ONE;
                    pow_we      = 1'b1;
                    pow_waddr   = '0;
                    pow_wdata   = {Q30_ONE, Q30_ONE};
                    idx_next    = ADDR_W'(1);
                    state_next  = S_POW_MUP;
                end
            end
            // Power table, one factor product after the other.
            S_POW_MUP:
            begin
                mul_start  = 1'b1;
                mul_a      = up_cur_reg;
                mul_b      = WIDE_W'(up_factor_reg);
                state_next = S_POW_WUP;
            end
            S_POW_WUP:
            begin
                if (!mul_busy)
                begin
                    up_cur_next = mul_res;
                    state_next  = S_POW_MDN;
                end
            end
            S_POW_MDN:
            begin
                mul_start  = 1'b1;
                mul_a      = dn_cur_reg;
                mul_b      = WIDE_W'(down_factor_reg);
                state_next = S_POW_WDN;
            end
            S_POW_WDN:
            begin
                if (!mul_busy)
                begin
                    dn_cur_next = mul_res;
                    pow_we      = 1'b1;
                    if (idx_reg == n_reg)
                    begin
                        idx_next   = '0;
                        leaf_next  = 1'b1;
                        state_next = S_PR_RDU;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = S_POW_MUP;
                    end
                end
            end
            // Node price: two table reads and two products.
            S_PR_RDU:
            begin
                pow_re     = 1'b1;
                pow_raddr  = leaf_reg ? (n_reg - idx_reg) : (idx_reg - ADDR_W'(1) - j_reg);
                state_next = S_PR_RDD;
            end
            S_PR_RDD:
            begin
                up_sel_next = pow_rdata_reg[2*WIDE_W-1:WIDE_W];
                pow_re      = 1'b1;
                pow_raddr   = leaf_reg ? idx_reg : j_reg;
                state_next  = S_PR_M1;
            end
            S_PR_M1:
            begin
                dn_sel_next = pow_rdata_reg[WIDE_W-1:0];
                mul_start   = 1'b1;
                mul_a       = WIDE_W'(spot_reg);
                mul_b       = up_sel_reg;
                state_next  = S_PR_W1;
            end
            S_PR_W1:
            begin
                if (!mul_busy)
                begin
                    state_next = S_PR_M2;
                end
            end
            S_PR_M2:
            begin
                mul_start  = 1'b1;
                state_next = S_PR_W2;
            end
            S_PR_W2:
            begin
                if (!mul_busy)
                begin
                    price_next = price_sat[PRICE_W-1:0];
                    state_next = leaf_reg ? S_LEAF_WR : S_ND_WAIT;
                end
            end
            // Leaves hold the intrinsic payoffs.
            S_LEAF_WR:
            begin
                node_we    = 1'b1;
                node_waddr = idx_reg;
                node_wdata = {(price_reg > strike_reg) ? (price_reg - strike_reg) : '0,
                              (strike_reg > price_reg) ? (strike_reg - price_reg) : '0};
                if (idx_reg == n_reg)
                begin
                    leaf_next  = 1'b0;
                    j_next     = '0;
                    state_next = S_ND_RD0;
                end
                else
                begin
                    idx_next   = idx_reg + ADDR_W'(1);
                    state_next = S_PR_RDU;
                end
            end
            // Backward induction over level idx, node j.
            S_ND_RD0:
            begin
                node_re    = 1'b1;
                node_raddr = j_reg;
                state_next = S_ND_RD1;
            end
            S_ND_RD1:
            begin
                call_up_next = node_rdata_reg[2*PRICE_W-1:PRICE_W];
                put_up_next  = node_rdata_reg[PRICE_W-1:0];
                node_re      = 1'b1;
                node_raddr   = j_reg + ADDR_W'(1);
                state_next   = S_ND_RB;
            end
            S_ND_RB:
            begin
                rb_start   = 1'b1;
                state_next = amer_reg ? S_PR_RDU : S_ND_WAIT;
            end
            S_ND_WAIT:
            begin
                if (!rb_call_busy && !rb_put_busy)
                begin
                    state_next = S_ND_WR;
                end
            end
            S_ND_WR:
            begin
                node_we       = 1'b1;
                call_out_next = node_call;
                put_out_next  = node_put;
                if (j_reg == (idx_reg - ADDR_W'(1)))
                begin
                    if (idx_reg == ADDR_W'(1))
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - ADDR_W'(1);
                        j_next     = '0;
                        state_next = S_ND_RD0;
                    end
                end
                else
                begin
                    j_next     = j_reg + ADDR_W'(1);
                    state_next = S_ND_RD0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        j_reg        <= j_next;
        leaf_reg     <= leaf_next;
        n_reg        <= n_next;
        p_reg        <= p_next;
        disc_reg     <= disc_next;
        amer_reg     <= amer_next;
        spot_reg     <= spot_next;
        strike_reg   <= strike_next;
        up_cur_reg   <= up_cur_next;
        dn_cur_reg   <= dn_cur_next;
        up_sel_reg   <= up_sel_next;
        dn_sel_reg   <= dn_sel_next;
        price_reg    <= price_next;
        call_up_reg  <= call_up_next;
        put_up_reg   <= put_up_next;
        call_out_reg <= call_out_next;
        put_out_reg  <= put_out_next;
    end

    // Power store.
    always_ff @(posedge clk)
    begin
        if (pow_we)
        begin
            pow_mem[pow_waddr] <= pow_wdata;
        end
        if (pow_re)
        begin
            pow_rdata_reg <= pow_mem[pow_raddr];
        end
    end

    // Node store.
    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (node_re)
        begin
            node_rdata_reg <= node_mem[node_raddr];
        end
    end

    btop_mulq30 u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .busy   (mul_busy),
        .result (mul_res)
    );

    btop_rollback u_rb_call (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (rb_start),
        .prob   (p_reg),
        .disc   (disc_reg),
        .up_val (call_up_reg),
        .dn_val (node_rdata_reg[2*PRICE_W-1:PRICE_W]),
        .busy   (rb_call_busy),
        .result (rb_call_res)
    );

    btop_rollback u_rb_put (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (rb_start),
        .prob   (p_reg),
        .disc   (disc_reg),
        .up_val (put_up_reg),
        .dn_val (node_rdata_reg[PRICE_W-1:0]),
        .busy   (rb_put_busy),
        .result (rb_put_res)
    );

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign call_value = call_out_reg;
    assign put_value  = put_out_reg;

    // Checks on the sequencer.
    `BTOP_ASSERT_IMPLY(a_done_when_idle, done, !busy)
    `BTOP_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
    `BTOP_ASSERT_IMPLY(a_node_addr_in_tree, node_we, node_waddr <= n_reg)
    `BTOP_ASSERT_IMPLY(a_mul_start_when_free, mul_start, !mul_busy)
    `BTOP_ASSERT_IMPLY(a_rb_start_when_free, rb_start, !rb_call_busy && !rb_put_busy)

endmodule
